@@ hdl/ust_pkg.sv @@
// types, codes and constants shared by the url stream tokenizer modules
// depends on nothing
`default_nettype none

package ust_pkg;

  typedef enum logic [2:0] {
    PH_PROTO,
    PH_SLASH1,
    PH_SLASH2,
    PH_HOST,
    PH_PORT,
    PH_PATH,
    PH_ERROR
  } phase_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_FLUSH,
    ST_SEG,
    ST_DOT,
    ST_TAIL,
    ST_SUM
  } ctl_state_t;

  // what follows a flush of the held bytes
  typedef enum logic [1:0] {
    AF_TAIL,
    AF_SEG,
    AF_DOT,
    AF_SUM
  } after_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_EXEC,
    OP_FLUSH,
    OP_SEG,
    OP_DOT,
    OP_SUM
  } dp_op_t;

  localparam logic [2:0] KIND_PROTO = 3'd0;
  localparam logic [2:0] KIND_HOST  = 3'd1;
  localparam logic [2:0] KIND_PATH  = 3'd2;
  localparam logic [2:0] KIND_SEG   = 3'd3;
  localparam logic [2:0] KIND_SUM   = 3'd4;

  localparam logic [1:0] ERR_NONE       = 2'd0;
  localparam logic [1:0] ERR_SYNTAX     = 2'd1;
  localparam logic [1:0] ERR_PROTO_LONG = 2'd2;
  localparam logic [1:0] ERR_PORT_OVF   = 2'd3;

  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  localparam logic [15:0] PORT_MAX = 16'hFFFF;
  localparam logic [7:0]  SEG_MAX  = 8'hFF;

  typedef struct packed {
    logic   latch;
    dp_op_t op;
    logic   flush_path;
    logic   flush_done;
    logic   last_of_run;
  } ust_cmd_t;

  typedef struct packed {
    phase_t phase;
    logic   is_colon;
    logic   is_slash;
    logic   is_dot;
    logic   pend_zero;
    logic   flush_last;
    logic   last_flag;
    logic   out_free;
  } ust_sts_t;

endpackage

`default_nettype wire

@@ hdl/ust_dp.sv @@
// datapath: parse state, held protocol bytes, port accumulator, result register
// depends on ust_pkg
`default_nettype none

module ust_dp import ust_pkg::*; #(
  parameter int PROTO_MAX = 16
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic [7:0] in_char_in,
  input  wire logic       in_end_of_url,
  input  wire ust_cmd_t   cmd,
  output ust_sts_t        sts,
  input  wire logic       out_ready,
  output logic            out_valid,
  output logic [2:0]      out_kind,
  output logic [7:0]      out_char_value,
  output logic [7:0]      out_segment_index,
  output logic [15:0]     out_port_value,
  output logic [1:0]      out_error_code,
  output logic            out_starts_at_root,
  output logic [7:0]      out_segment_count,
  output logic            out_last_of_run
);

  localparam int CW = $clog2(PROTO_MAX + 1);
  localparam int PW = (PROTO_MAX > 1) ? $clog2(PROTO_MAX) : 1;
  localparam logic [CW-1:0] PEND_MAX = CW'(PROTO_MAX);

  logic [7:0]    char_r;
  logic          last_r;
  phase_t        phase_r, phase_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [15:0]   port_r, port_nxt;
  logic [7:0]    seg_r, seg_nxt;
  logic          root_r, root_nxt;
  logic [1:0]    err_r, err_nxt;
  logic [PW-1:0] ptr_r, ptr_nxt;
  logic [7:0]    rd_data_r;
  logic [7:0]    mem [PROTO_MAX];

  logic          out_valid_r;
  logic [2:0]    kind_r;
  logic [7:0]    char_val_r;
  logic [7:0]    idx_r;
  logic [15:0]   port_out_r;
  logic [1:0]    err_out_r;
  logic          root_out_r;
  logic [7:0]    seg_out_r;
  logic          lor_r;

  logic          wr_en;
  logic          emit;
  logic          use_idx;
  logic [2:0]    e_kind;
  logic [7:0]    e_char;
  logic [7:0]    e_idx;
  logic [7:0]    seg_inc;
  logic          is_digit;
  logic [19:0]   port_sum;
  logic          out_free;

  assign seg_inc  = (seg_r == SEG_MAX) ? seg_r : seg_r + 8'd1;
  assign is_digit = (char_r >= CH_ZERO) && (char_r <= CH_NINE);
  assign port_sum = ({4'b0, port_r} << 3) + ({4'b0, port_r} << 1)
                  + 20'(char_r[3:0] - CH_ZERO[3:0]);
  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    phase_nxt = phase_r;
    cnt_nxt   = cnt_r;
    port_nxt  = port_r;
    seg_nxt   = seg_r;
    root_nxt  = root_r;
    err_nxt   = err_r;
    ptr_nxt   = ptr_r;
    wr_en     = 1'b0;
    emit      = 1'b0;
    use_idx   = 1'b0;
    e_kind    = KIND_PROTO;
    e_char    = 8'd0;
    case (cmd.op)
      OP_EXEC: begin
        case (phase_r)
          PH_PROTO: begin
            if (char_r == CH_COLON) begin
              phase_nxt = PH_SLASH1;
            end else if (char_r == CH_SLASH) begin
              if (cnt_r == '0) begin
                root_nxt = 1'b1;
              end
              seg_nxt   = seg_inc;
              emit      = 1'b1;
              e_kind    = KIND_SEG;
              use_idx   = 1'b1;
              phase_nxt = PH_PATH;
            end else if (char_r == CH_DOT) begin
              seg_nxt   = seg_inc;
              emit      = 1'b1;
              e_kind    = KIND_SEG;
              use_idx   = 1'b1;
              phase_nxt = PH_PATH;
            end else if (cnt_r >= PEND_MAX) begin
              err_nxt   = ERR_PROTO_LONG;
              phase_nxt = PH_ERROR;
            end else begin
              wr_en   = 1'b1;
              cnt_nxt = cnt_r + CW'(1);
            end
          end
          PH_SLASH1: begin
            if (char_r == CH_SLASH) begin
              phase_nxt = PH_SLASH2;
            end else begin
              err_nxt   = ERR_SYNTAX;
              phase_nxt = PH_ERROR;
            end
          end
          PH_SLASH2: begin
            if (char_r == CH_SLASH) begin
              phase_nxt = PH_HOST;
            end else begin
              err_nxt   = ERR_SYNTAX;
              phase_nxt = PH_ERROR;
            end
          end
          PH_HOST: begin
            if (char_r == CH_SLASH) begin
              seg_nxt   = seg_inc;
              emit      = 1'b1;
              e_kind    = KIND_SEG;
              use_idx   = 1'b1;
              phase_nxt = PH_PATH;
            end else if (char_r == CH_COLON) begin
              phase_nxt = PH_PORT;
            end else begin
              emit   = 1'b1;
              e_kind = KIND_HOST;
              e_char = char_r;
            end
          end
          PH_PORT: begin
            if (is_digit) begin
              if (port_sum > 20'(PORT_MAX)) begin
                port_nxt  = PORT_MAX;
                err_nxt   = ERR_PORT_OVF;
                phase_nxt = PH_ERROR;
              end else begin
                port_nxt = port_sum[15:0];
              end
            end else if (char_r == CH_SLASH) begin
              seg_nxt   = seg_inc;
              emit      = 1'b1;
              e_kind    = KIND_SEG;
              use_idx   = 1'b1;
              phase_nxt = PH_PATH;
            end else begin
              err_nxt   = ERR_SYNTAX;
              phase_nxt = PH_ERROR;
            end
          end
          PH_PATH: begin
            emit    = 1'b1;
            use_idx = 1'b1;
            if (char_r == CH_SLASH) begin
              seg_nxt = seg_inc;
              e_kind  = KIND_SEG;
            end else begin
              e_kind = KIND_PATH;
              e_char = char_r;
            end
          end
          default: begin
          end
        endcase
      end
      OP_FLUSH: begin
        emit    = 1'b1;
        e_kind  = cmd.flush_path ? KIND_PATH : KIND_PROTO;
        e_char  = rd_data_r;
        use_idx = cmd.flush_path;
        if (cmd.flush_done) begin
          cnt_nxt = '0;
          ptr_nxt = '0;
        end else begin
          ptr_nxt = ptr_r + PW'(1);
        end
      end
      OP_SEG: begin
        seg_nxt = seg_inc;
        emit    = 1'b1;
        e_kind  = KIND_SEG;
        use_idx = 1'b1;
      end
      OP_DOT: begin
        emit    = 1'b1;
        e_kind  = KIND_PATH;
        e_char  = char_r;
        use_idx = 1'b1;
      end
      OP_SUM: begin
        emit   = 1'b1;
        e_kind = KIND_SUM;
      end
      default: begin
      end
    endcase
  end

  assign e_idx = (use_idx && seg_nxt != 8'd0) ? seg_nxt - 8'd1 : 8'd0;

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      char_r <= in_char_in;
      last_r <= in_end_of_url;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_PROTO;
      cnt_r   <= '0;
      port_r  <= '0;
      seg_r   <= '0;
      root_r  <= 1'b0;
      err_r   <= ERR_NONE;
      ptr_r   <= '0;
    end else if (cmd.op == OP_SUM) begin
      phase_r <= PH_PROTO;
      cnt_r   <= '0;
      port_r  <= '0;
      seg_r   <= '0;
      root_r  <= 1'b0;
      err_r   <= ERR_NONE;
      ptr_r   <= '0;
    end else begin
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
      port_r  <= port_nxt;
      seg_r   <= seg_nxt;
      root_r  <= root_nxt;
      err_r   <= err_nxt;
      ptr_r   <= ptr_nxt;
    end
  end

  // held protocol bytes
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[cnt_r[PW-1:0]] <= char_r;
    end
    rd_data_r <= mem[ptr_nxt];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      kind_r     <= e_kind;
      char_val_r <= e_char;
      idx_r      <= e_idx;
      port_out_r <= port_nxt;
      err_out_r  <= err_nxt;
      root_out_r <= root_nxt;
      seg_out_r  <= seg_nxt;
      lor_r      <= cmd.last_of_run;
    end
  end

  always_comb begin
    sts.phase      = phase_r;
    sts.is_colon   = (char_r == CH_COLON);
    sts.is_slash   = (char_r == CH_SLASH);
    sts.is_dot     = (char_r == CH_DOT);
    sts.pend_zero  = (cnt_r == '0);
    sts.flush_last = ((CW'(ptr_r) + CW'(1)) == cnt_r);
    sts.last_flag  = last_r;
    sts.out_free   = out_free;
  end

  assign out_valid          = out_valid_r;
  assign out_kind           = kind_r;
  assign out_char_value     = char_val_r;
  assign out_segment_index  = idx_r;
  assign out_port_value     = port_out_r;
  assign out_error_code     = err_out_r;
  assign out_starts_at_root = root_out_r;
  assign out_segment_count  = seg_out_r;
  assign out_last_of_run    = lor_r;

endmodule

`default_nettype wire

@@ hdl/ust_ctrl.sv @@
// controller: sequences the steps of one request and issues datapath commands
// depends on ust_pkg
`default_nettype none

module ust_ctrl import ust_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire ust_sts_t sts,
  output ust_cmd_t      cmd
);

  ctl_state_t state_r, state_nxt;
  after_t     after_r, after_nxt;
  logic       in_proto;

  assign in_proto = (sts.phase == PH_PROTO);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      after_r <= AF_TAIL;
    end else begin
      state_r <= state_nxt;
      after_r <= after_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    after_nxt = after_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (sts.out_free) begin
          state_nxt = ST_TAIL;
          if (in_proto && !sts.pend_zero) begin
            if (sts.is_colon) begin
              state_nxt = ST_FLUSH;
              after_nxt = AF_TAIL;
            end else if (sts.is_slash) begin
              state_nxt = ST_FLUSH;
              after_nxt = AF_SEG;
            end else if (sts.is_dot) begin
              state_nxt = ST_FLUSH;
              after_nxt = AF_DOT;
            end
          end else if (in_proto && sts.is_dot) begin
            state_nxt = ST_DOT;
          end
        end
      end
      ST_FLUSH: begin
        if (sts.out_free && sts.flush_last) begin
          case (after_r)
            AF_TAIL: state_nxt = ST_TAIL;
            AF_SEG:  state_nxt = ST_SEG;
            AF_DOT:  state_nxt = ST_DOT;
            AF_SUM:  state_nxt = ST_SUM;
            default: state_nxt = ST_TAIL;
          endcase
        end
      end
      ST_SEG, ST_DOT: begin
        if (sts.out_free) begin
          state_nxt = ST_TAIL;
        end
      end
      ST_TAIL: begin
        if (sts.out_free) begin
          if (!sts.last_flag) begin
            state_nxt = ST_IDLE;
          end else if (in_proto && !sts.pend_zero) begin
            state_nxt = ST_FLUSH;
            after_nxt = AF_SUM;
          end else begin
            state_nxt = ST_SUM;
          end
        end
      end
      ST_SUM: begin
        if (sts.out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready        = (state_r == ST_IDLE);
    cmd.latch       = (state_r == ST_IDLE) && in_valid;
    cmd.op          = OP_NONE;
    cmd.flush_path  = (after_r == AF_SEG) || (after_r == AF_DOT);
    cmd.flush_done  = sts.flush_last;
    cmd.last_of_run = 1'b0;
    case (state_r)
      ST_EXEC: begin
        if (sts.out_free) begin
          cmd.op = OP_EXEC;
        end
        cmd.last_of_run = !sts.last_flag &&
          !(in_proto && ((sts.is_slash && !sts.pend_zero) || sts.is_dot));
      end
      ST_FLUSH: begin
        if (sts.out_free) begin
          cmd.op = OP_FLUSH;
        end
        cmd.last_of_run = sts.flush_last && (after_r == AF_TAIL) && !sts.last_flag;
      end
      ST_SEG: begin
        if (sts.out_free) begin
          cmd.op = OP_SEG;
        end
        cmd.last_of_run = !sts.last_flag;
      end
      ST_DOT: begin
        if (sts.out_free) begin
          cmd.op = OP_DOT;
        end
        cmd.last_of_run = !sts.last_flag;
      end
      ST_SUM: begin
        if (sts.out_free) begin
          cmd.op = OP_SUM;
        end
        cmd.last_of_run = 1'b1;
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

@@ hdl/url_stream_tokenizer.sv @@
// url stream tokenizer: one byte per request; the first result of a byte is registered
// at the earliest in the execute step after the byte is accepted; a byte takes accept,
// execute and tail steps plus a step for each held byte flushed, for a second segment start,
// for a protocol-phase dot and for the summary on the final byte, plus out_ready stalls
// synchronous active-low reset returns the parser to the protocol phase
// depends on ust_pkg, ust_ctrl, ust_dp
`default_nettype none

module url_stream_tokenizer import ust_pkg::*; #(
  parameter int PROTO_MAX = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_char_in,
  input  wire logic        in_end_of_url,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [2:0]       out_kind,
  output logic [7:0]       out_char_value,
  output logic [7:0]       out_segment_index,
  output logic [15:0]      out_port_value,
  output logic [1:0]       out_error_code,
  output logic             out_starts_at_root,
  output logic [7:0]       out_segment_count,
  output logic             out_last_of_run
);

  ust_cmd_t cmd;
  ust_sts_t sts;

  ust_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  ust_dp #(
    .PROTO_MAX (PROTO_MAX)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_char_in         (in_char_in),
    .in_end_of_url      (in_end_of_url),
    .cmd                (cmd),
    .sts                (sts),
    .out_ready          (out_ready),
    .out_valid          (out_valid),
    .out_kind           (out_kind),
    .out_char_value     (out_char_value),
    .out_segment_index  (out_segment_index),
    .out_port_value     (out_port_value),
    .out_error_code     (out_error_code),
    .out_starts_at_root (out_starts_at_root),
    .out_segment_count  (out_segment_count),
    .out_last_of_run    (out_last_of_run)
  );

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.op != OP_NONE |-> sts.out_free)
    else $error("result issued while result register is full");

  a_summary_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_SUM |-> out_last_of_run && out_char_value == 8'd0)
    else $error("summary result is not the last of its request");

  a_seg_index: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_SEG |->
      out_char_value == 8'd0 && out_segment_index == out_segment_count - 8'd1)
    else $error("segment start index does not follow segment count");

endmodule

`default_nettype wire

@@ tb/ust_checker.sv @@
// checker for the url stream tokenizer: predicts the result stream from accepted bytes
// and compares every accepted result field by field; depends on ust_pkg
module ust_checker import ust_pkg::*; #(
  parameter int PROTO_MAX = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  input  wire logic        in_ready,
  input  wire logic [7:0]  in_char_in,
  input  wire logic        in_end_of_url,
  input  wire logic        out_valid,
  input  wire logic        out_ready,
  input  wire logic [2:0]  out_kind,
  input  wire logic [7:0]  out_char_value,
  input  wire logic [7:0]  out_segment_index,
  input  wire logic [15:0] out_port_value,
  input  wire logic [1:0]  out_error_code,
  input  wire logic        out_starts_at_root,
  input  wire logic [7:0]  out_segment_count,
  input  wire logic        out_last_of_run,
  output int               mismatch_count,
  output int               tokens_due
);

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  char_value;
    logic [7:0]  segment_index;
    logic [15:0] port_value;
    logic [1:0]  error_code;
    logic        starts_at_root;
    logic [7:0]  segment_count;
    logic        last_of_run;
  } token_t;

  token_t     expected_tokens[$];
  phase_t     phase;
  logic [7:0] held_bytes [PROTO_MAX];
  int         held_cnt;
  int         port_acc;
  int         seg_cnt;
  logic       root_seen;
  logic [1:0] err_code;
  int         fail_total = 0;

  initial begin
    mismatch_count = 0;
    tokens_due = 0;
  end

  function automatic logic [7:0] cur_index();
    return (seg_cnt != 0) ? 8'(seg_cnt - 1) : 8'd0;
  endfunction

  task automatic emit_token(input logic [2:0] kind, input logic [7:0] ch,
                            input logic [7:0] idx);
    token_t tok;
    tok.kind           = kind;
    tok.char_value     = ch;
    tok.segment_index  = idx;
    tok.port_value     = port_acc[15:0];
    tok.error_code     = err_code;
    tok.starts_at_root = root_seen;
    tok.segment_count  = seg_cnt[7:0];
    tok.last_of_run    = 1'b0;
    expected_tokens.insert(expected_tokens.size(), tok);
  endtask

  task automatic open_segment();
    if (seg_cnt < 255) seg_cnt++;
    emit_token(KIND_SEG, 8'd0, cur_index());
  endtask

  task automatic release_held(input logic [2:0] kind);
    for (int i = 0; i < held_cnt; i++) begin
      emit_token(kind, held_bytes[i], (kind == KIND_PATH) ? cur_index() : 8'd0);
    end
    held_cnt = 0;
  endtask

  task automatic fail_parse(input logic [1:0] code);
    err_code = code;
    phase    = PH_ERROR;
  endtask

  task automatic clear_parse();
    held_cnt  = 0;
    phase     = PH_PROTO;
    port_acc  = 0;
    seg_cnt   = 0;
    root_seen = 1'b0;
    err_code  = ERR_NONE;
  endtask

  task automatic tokenize_byte(input logic [7:0] c, input logic last);
    int     base;
    int     v;
    token_t tok;
    base = expected_tokens.size();
    case (phase)
      PH_PROTO: begin
        if (c == CH_COLON) begin
          release_held(KIND_PROTO);
          phase = PH_SLASH1;
        end else if (c == CH_SLASH) begin
          if (held_cnt == 0) begin
            root_seen = 1'b1;
          end else begin
            open_segment();
            release_held(KIND_PATH);
          end
          open_segment();
          phase = PH_PATH;
        end else if (c == CH_DOT) begin
          open_segment();
          release_held(KIND_PATH);
          emit_token(KIND_PATH, c, cur_index());
          phase = PH_PATH;
        end else if (held_cnt >= PROTO_MAX) begin
          fail_parse(ERR_PROTO_LONG);
        end else begin
          held_bytes[held_cnt] = c;
          held_cnt++;
        end
      end
      PH_SLASH1: begin
        if (c == CH_SLASH) phase = PH_SLASH2;
        else fail_parse(ERR_SYNTAX);
      end
      PH_SLASH2: begin
        if (c == CH_SLASH) phase = PH_HOST;
        else fail_parse(ERR_SYNTAX);
      end
      PH_HOST: begin
        if (c == CH_SLASH) begin
          open_segment();
          phase = PH_PATH;
        end else if (c == CH_COLON) begin
          phase = PH_PORT;
        end else begin
          emit_token(KIND_HOST, c, 8'd0);
        end
      end
      PH_PORT: begin
        if (c >= CH_ZERO && c <= CH_NINE) begin
          v = port_acc * 10 + int'(c) - int'(CH_ZERO);
          if (v > int'(PORT_MAX)) begin
            port_acc = int'(PORT_MAX);
            fail_parse(ERR_PORT_OVF);
          end else begin
            port_acc = v;
          end
        end else if (c == CH_SLASH) begin
          open_segment();
          phase = PH_PATH;
        end else begin
          fail_parse(ERR_SYNTAX);
        end
      end
      PH_PATH: begin
        if (c == CH_SLASH) open_segment();
        else emit_token(KIND_PATH, c, cur_index());
      end
      default: ;
    endcase
    if (last) begin
      if (phase == PH_PROTO) release_held(KIND_PROTO);
      emit_token(KIND_SUM, 8'd0, 8'd0);
      clear_parse();
    end
    if (expected_tokens.size() > base) begin
      tok = expected_tokens[expected_tokens.size() - 1];
      tok.last_of_run = 1'b1;
      expected_tokens[expected_tokens.size() - 1] = tok;
    end
  endtask

  task automatic note_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      fail_total++;
    end
  endtask

  always @(posedge clk) begin : watch
    token_t want;
    if (!rst_n) begin
      expected_tokens.delete();
      clear_parse();
    end else begin
      if (out_valid && out_ready) begin
        if (expected_tokens.size() == 0) begin
          $display("%0t: unexpected result, expected none, got kind %0d char %0d",
                   $time, out_kind, out_char_value);
          fail_total++;
        end else begin
          want = expected_tokens.pop_front();
          note_field("kind", want.kind, out_kind);
          note_field("char_value", want.char_value, out_char_value);
          note_field("segment_index", want.segment_index, out_segment_index);
          note_field("port_value", want.port_value, out_port_value);
          note_field("error_code", want.error_code, out_error_code);
          note_field("starts_at_root", want.starts_at_root, out_starts_at_root);
          note_field("segment_count", want.segment_count, out_segment_count);
          note_field("last_of_run", want.last_of_run, out_last_of_run);
        end
      end
      if (in_valid && in_ready) tokenize_byte(in_char_in, in_end_of_url);
    end
    mismatch_count <= fail_total;
    tokens_due     <= expected_tokens.size();
  end

endmodule

@@ tb/tb.sv @@
// top of the url stream tokenizer testbench: reset, byte requests built from
// url-like strings, random idling on both channels, verdict; depends on ust_pkg,
// url_stream_tokenizer and ust_checker
module tb import ust_pkg::*;;

  localparam int PROTO_MAX = 16;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  in_char_in;
  logic        in_end_of_url;
  logic        out_valid;
  logic        out_ready;
  logic [2:0]  out_kind;
  logic [7:0]  out_char_value;
  logic [7:0]  out_segment_index;
  logic [15:0] out_port_value;
  logic [1:0]  out_error_code;
  logic        out_starts_at_root;
  logic [7:0]  out_segment_count;
  logic        out_last_of_run;
  int          mismatch_count;
  int          tokens_due;

  logic        calm = 1'b0;
  int          bytes_sent = 0;
  logic [7:0]  url_bytes[$];

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  url_stream_tokenizer #(.PROTO_MAX(PROTO_MAX)) i_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_char_in         (in_char_in),
    .in_end_of_url      (in_end_of_url),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_kind           (out_kind),
    .out_char_value     (out_char_value),
    .out_segment_index  (out_segment_index),
    .out_port_value     (out_port_value),
    .out_error_code     (out_error_code),
    .out_starts_at_root (out_starts_at_root),
    .out_segment_count  (out_segment_count),
    .out_last_of_run    (out_last_of_run)
  );

  ust_checker #(.PROTO_MAX(PROTO_MAX)) i_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_char_in         (in_char_in),
    .in_end_of_url      (in_end_of_url),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_kind           (out_kind),
    .out_char_value     (out_char_value),
    .out_segment_index  (out_segment_index),
    .out_port_value     (out_port_value),
    .out_error_code     (out_error_code),
    .out_starts_at_root (out_starts_at_root),
    .out_segment_count  (out_segment_count),
    .out_last_of_run    (out_last_of_run),
    .mismatch_count     (mismatch_count),
    .tokens_due         (tokens_due)
  );

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (calm) return 0;
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [7:0] plain_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255));
    while (b == CH_COLON || b == CH_SLASH || b == CH_DOT);
    return b;
  endfunction

  function automatic logic [7:0] host_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255));
    while (b == CH_COLON || b == CH_SLASH);
    return b;
  endfunction

  function automatic logic [7:0] path_byte();
    logic [7:0] b;
    do b = ($urandom_range(0, 7) == 0) ? CH_DOT : 8'($urandom_range(0, 255));
    while (b == CH_SLASH);
    return b;
  endfunction

  task automatic send_byte(input logic [7:0] c, input logic last);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_char_in    <= c;
    in_end_of_url <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic send_url();
    calm = ($urandom_range(0, 5) == 0);
    foreach (url_bytes[i]) send_byte(url_bytes[i], i == url_bytes.size() - 1);
    url_bytes.delete();
  endtask

  task automatic add_byte(input logic [7:0] b);
    url_bytes.insert(url_bytes.size(), b);
  endtask

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) add_byte(s[i]);
  endtask

  task automatic add_plain(input int n);
    repeat (n) add_byte(plain_byte());
  endtask

  task automatic add_noise(input int n);
    repeat (n) add_byte(8'($urandom_range(0, 255)));
  endtask

  task automatic add_path(input int segs);
    repeat (segs) begin
      add_byte(CH_SLASH);
      repeat ($urandom_range(0, 4)) add_byte(path_byte());
    end
  endtask

  task automatic add_port();
    case ($urandom_range(0, 5))
      0: add_text("65535");
      1: add_text("65536");
      2: add_text($sformatf("%0d", $urandom_range(65536, 999999)));
      3: add_text($sformatf("00%0d", $urandom_range(0, 99)));
      default: add_text($sformatf("%0d", $urandom_range(0, 65535)));
    endcase
  endtask

  task automatic build_url();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) begin
      // scheme, host, optional port, path
      add_plain($urandom_range(0, 5));
      add_text("://");
      repeat ($urandom_range(0, 6)) add_byte(host_byte());
      if ($urandom_range(0, 2) == 0) begin
        add_byte(CH_COLON);
        add_port();
      end
      add_path($urandom_range(0, 3));
    end else if (r < 65) begin
      // relative or rooted path
      case ($urandom_range(0, 2))
        0: ;
        1: add_plain($urandom_range(1, 4));
        default: begin
          add_plain($urandom_range(0, 3));
          add_byte(CH_DOT);
        end
      endcase
      add_path($urandom_range(1, 3));
    end else if (r < 75) begin
      // held bytes, sometimes past the buffer size, sometimes followed by noise
      if ($urandom_range(0, 1) == 0) add_plain($urandom_range(0, 6));
      else add_plain($urandom_range(PROTO_MAX - 1, PROTO_MAX + 3));
      if ($urandom_range(0, 3) == 0) add_noise($urandom_range(1, 3));
    end else if (r < 85) begin
      // missing or broken slashes after the scheme
      add_plain($urandom_range(0, 3));
      add_byte(CH_COLON);
      if ($urandom_range(0, 1) == 0) add_byte(CH_SLASH);
      add_byte(plain_byte());
      add_noise($urandom_range(0, 3));
    end else if (r < 92) begin
      // bad port byte or port overflow
      add_plain($urandom_range(0, 2));
      add_text("://");
      add_plain($urandom_range(0, 2));
      add_byte(CH_COLON);
      if ($urandom_range(0, 1) == 0) begin
        add_text($sformatf("%0d", $urandom_range(0, 999)));
        add_byte(plain_byte());
      end else begin
        add_text($sformatf("%0d", $urandom_range(65536, 999999)));
      end
      add_noise($urandom_range(0, 3));
    end else begin
      add_noise($urandom_range(1, 8));
    end
    if (url_bytes.size() == 0) add_byte(plain_byte());
  endtask

  initial begin : ready_pattern
    int g;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      g = gap_len();
      if (g > 0) begin
        out_ready <= 1'b0;
        repeat (g) @(posedge clk);
      end
      out_ready <= 1'b1;
      repeat ($urandom_range(0, 8)) @(posedge clk);
    end
  end

  initial begin
    #2000000;
    $display("CHECK FAILED");
    $finish;
  end

  initial begin : stimulus
    rst_n         <= 1'b0;
    in_valid      <= 1'b0;
    in_char_in    <= 8'd0;
    in_end_of_url <= 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // byte extremes ending in the protocol phase
    add_byte(8'h00);
    send_url();
    add_byte(8'hFF);
    send_url();
    // rooted path, held bytes before a slash, dot with no held bytes
    add_text("/");
    send_url();
    add_text("a/b");
    send_url();
    add_text(".x");
    send_url();
    // missing slash, bad port byte, port overflow
    add_text(":/x");
    send_url();
    add_text("://:7q");
    send_url();
    add_text("://:65536");
    send_url();

    while (bytes_sent < 260) begin
      build_url();
      send_url();
    end
    in_valid <= 1'b0;

    @(posedge clk);
    while (tokens_due != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
